/* rtl/tcpq_pkg.sv */
// Package for the two-class priority queue.
// Holds sizes, function and status codes, and the control structs shared between the modules.
// No dependencies.
package tcpq_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = 5;
	localparam int ID_W   = 16;
	localparam int FUNC_W = 2;
	localparam int POS_W  = 4;
	localparam int STAT_W = 2;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT  = 2'd0,
		FN_EXTRACT = 2'd1,
		FN_PEEK    = 2'd2,
		FN_QUERY   = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [ID_W-1:0]  wr_data;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

	typedef struct packed {
		status_t          status;
		logic             use_mem;
		logic             sel_pri;
		logic             oprio;
		logic [CNT_W-1:0] count;
		logic             full;
		logic             empty;
	} rsp_ctl_t;

	function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

/* rtl/tcpq_if.sv */
// Channel interfaces of the two-class priority queue: request, response, configuration.
// Depends on tcpq_pkg for field widths.
interface tcpq_req_if;
	logic                        valid;
	logic                        ready;
	logic [tcpq_pkg::FUNC_W-1:0] func;
	logic [tcpq_pkg::ID_W-1:0]   item_id;
	logic                        is_priority;
	logic [tcpq_pkg::POS_W-1:0]  position;

	modport source (output valid, func, item_id, is_priority, position, input ready);
	modport sink (input valid, func, item_id, is_priority, position, output ready);
endinterface

interface tcpq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tcpq_pkg::STAT_W-1:0] status;
	logic [tcpq_pkg::ID_W-1:0]   out_id;
	logic                        out_priority;
	logic [tcpq_pkg::CNT_W-1:0]  item_count;
	logic                        full_flag;
	logic                        empty_flag;

	modport source (output valid, status, out_id, out_priority, item_count, full_flag,
		empty_flag, input ready);
	modport sink (input valid, status, out_id, out_priority, item_count, full_flag,
		empty_flag, output ready);
endinterface

interface tcpq_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [tcpq_pkg::CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/tcpq_mem.sv */
// Identifier store of one service class: one write port, one registered read port.
// Depends on tcpq_pkg.
module tcpq_mem (
	input  logic                      clk,
	input  tcpq_pkg::mem_req_t        req,
	output logic [tcpq_pkg::ID_W-1:0] rd_data
);
	import tcpq_pkg::*;

	logic [ID_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem_q[req.rd_addr];
		end
	end

endmodule

/* rtl/tcpq_ctrl.sv */
// Queue control: counts, class ring pointers, capacity register and result status.
// Issues writes and head reads to the two class memories. Depends on tcpq_pkg.
module tcpq_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [tcpq_pkg::FUNC_W-1:0]  func,
	input  logic [tcpq_pkg::ID_W-1:0]    item_id,
	input  logic                         is_priority,
	input  logic [tcpq_pkg::POS_W-1:0]   position,
	input  logic                         cfg_we,
	input  logic [tcpq_pkg::CNT_W-1:0]   cfg_data,
	output tcpq_pkg::mem_req_t           preq,
	output tcpq_pkg::mem_req_t           nreq,
	output tcpq_pkg::rsp_ctl_t           ctl
);
	import tcpq_pkg::*;

	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] ent_q, ent_d;
	logic [CNT_W-1:0] pri_q, pri_d;
	logic [IDX_W-1:0] phead_q, phead_d, ptail_q, ptail_d;
	logic [IDX_W-1:0] nhead_q, nhead_d, ntail_q, ntail_d;
	logic [CNT_W-1:0] eff_cap;
	logic [CNT_W-1:0] pos_ext;

	assign eff_cap = (cap_q > DEPTH_CNT) ? DEPTH_CNT : cap_q;
	assign pos_ext = CNT_W'(position);

	always_comb begin
		ent_d   = ent_q;
		pri_d   = pri_q;
		phead_d = phead_q;
		ptail_d = ptail_q;
		nhead_d = nhead_q;
		ntail_d = ntail_q;
		preq    = '0;
		nreq    = '0;
		ctl     = '0;
		ctl.status = ST_OK;
		unique case (func_t'(func))
			FN_INSERT: begin
				if (ent_q >= eff_cap) begin
					ctl.status = ST_FULL;
				end else if (is_priority) begin
					preq.wr_en   = fire;
					preq.wr_addr = ptail_q;
					preq.wr_data = item_id;
					ptail_d      = ptr_inc(ptail_q);
					pri_d        = pri_q + 1'b1;
					ent_d        = ent_q + 1'b1;
				end else begin
					nreq.wr_en   = fire;
					nreq.wr_addr = ntail_q;
					nreq.wr_data = item_id;
					ntail_d      = ptr_inc(ntail_q);
					ent_d        = ent_q + 1'b1;
				end
			end
			FN_EXTRACT, FN_PEEK: begin
				if (ent_q == '0) begin
					ctl.status = ST_EMPTY;
				end else begin
					ctl.use_mem = 1'b1;
					ctl.sel_pri = (pri_q != '0);
					ctl.oprio   = (pri_q != '0);
					if (pri_q != '0) begin
						preq.rd_en   = fire;
						preq.rd_addr = phead_q;
					end else begin
						nreq.rd_en   = fire;
						nreq.rd_addr = nhead_q;
					end
					if (func_t'(func) == FN_EXTRACT) begin
						ent_d = ent_q - 1'b1;
						if (pri_q != '0) begin
							pri_d   = pri_q - 1'b1;
							phead_d = ptr_inc(phead_q);
						end else begin
							nhead_d = ptr_inc(nhead_q);
						end
					end
				end
			end
			FN_QUERY: begin
				if (pos_ext < eff_cap && pos_ext < ent_q) begin
					ctl.oprio = (pos_ext < pri_q);
				end else begin
					ctl.status = ST_RANGE;
				end
			end
			default: begin
				ctl.status = ST_OK;
			end
		endcase
		ctl.count = ent_d;
		ctl.full  = (ent_d >= eff_cap);
		ctl.empty = (ent_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			ent_q   <= '0;
			pri_q   <= '0;
			phead_q <= '0;
			ptail_q <= '0;
			nhead_q <= '0;
			ntail_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (fire) begin
				ent_q   <= ent_d;
				pri_q   <= pri_d;
				phead_q <= phead_d;
				ptail_q <= ptail_d;
				nhead_q <= nhead_d;
				ntail_q <= ntail_d;
			end
		end
	end

	a_pri_le_ent: assert property (@(posedge clk) disable iff (!arst_n)
		pri_q <= ent_q)
		else $error("priority count exceeds entry count");

	a_ent_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		ent_q <= DEPTH_CNT)
		else $error("entry count exceeds depth");

	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && func_t'(func) == FN_INSERT && ent_q >= eff_cap |=> $stable(ent_q))
		else $error("refused insert changed the count");

	a_no_rw_same: assert property (@(posedge clk) disable iff (!arst_n)
		!(preq.wr_en && preq.rd_en) && !(nreq.wr_en && nreq.rd_en))
		else $error("write and read issued to one class memory together");

endmodule

/* rtl/two_class_priority_queue.sv */
// Two-class priority queue: bounded queue whose priority entries are served
// before normal entries, each class in arrival order, both sharing one capacity.
//
// Channels: req (sink) carries func, item_id, is_priority, position; rsp
// (source) carries status, out_id, out_priority, item_count, full_flag,
// empty_flag; cfg (sink) writes the capacity register, always ready.
// A request is taken when valid and ready are both high; each request gives
// exactly one response, in request order.
// Timing: counts and pointers update when the request is taken, the head read
// of the class memory lands in the stage behind it, and the response register
// follows. One request per cycle is sustained while rsp does not stall.
// A stalled rsp holds the response register; the stage behind it then holds
// its request and req.ready drops until the response is taken.
// Reset empties the queue and sets the capacity to 16; memory contents are
// not cleared and need no clearing pass. Write cfg only while idle.
// Depends on tcpq_pkg, tcpq_if, tcpq_mem, tcpq_ctrl.
module two_class_priority_queue (
	input  logic       clk,
	input  logic       arst_n,
	tcpq_req_if.sink   req,
	tcpq_rsp_if.source rsp,
	tcpq_cfg_if.sink   cfg
);
	import tcpq_pkg::*;

	logic            fire;
	logic            advance;
	mem_req_t        preq, nreq;
	rsp_ctl_t        ctl;
	logic [ID_W-1:0] pdata, ndata;

	logic     vld_s1;
	rsp_ctl_t ctl_s1;
	logic     out_vld_q;

	logic [STAT_W-1:0] status_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_priority_q;
	logic [CNT_W-1:0]  item_count_q;
	logic              full_flag_q;
	logic              empty_flag_q;

	assign advance   = vld_s1 && (!out_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || advance;
	assign fire      = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	tcpq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.func        (req.func),
		.item_id     (req.item_id),
		.is_priority (req.is_priority),
		.position    (req.position),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg.data),
		.preq        (preq),
		.nreq        (nreq),
		.ctl         (ctl)
	);

	tcpq_mem u_pri_mem (
		.clk     (clk),
		.req     (preq),
		.rd_data (pdata)
	);

	tcpq_mem u_norm_mem (
		.clk     (clk),
		.req     (nreq),
		.rd_data (ndata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (fire) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ctl_s1 <= ctl;
		end
		if (advance) begin
			status_q       <= ctl_s1.status;
			out_id_q       <= ctl_s1.use_mem ? (ctl_s1.sel_pri ? pdata : ndata) : '0;
			out_priority_q <= ctl_s1.oprio;
			item_count_q   <= ctl_s1.count;
			full_flag_q    <= ctl_s1.full;
			empty_flag_q   <= ctl_s1.empty;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.status       = status_q;
	assign rsp.out_id       = out_id_q;
	assign rsp.out_priority = out_priority_q;
	assign rsp.item_count   = item_count_q;
	assign rsp.full_flag    = full_flag_q;
	assign rsp.empty_flag   = empty_flag_q;

endmodule
